>>> hw/rtl/bara_pkg.sv
package bara_pkg;

   // Fixed widths of a word and its fields.
   localparam int WORD_BITS     = 32;
   localparam int SEL_W         = 5;     // bit select within a word
   localparam int OP_W          = 2;
   localparam int IDX_W         = 15;
   localparam int END_W         = 16;
   localparam int WIDX_W        = IDX_W - SEL_W;  // word index carried by an item
   localparam int WORDS_MAX     = 2 ** WIDX_W;    // words an item can ever reach
   localparam int CNT_W         = WIDX_W + 1;     // word counter, holds WORDS_MAX
   localparam int NUM_WORDS_DEF = 1024;

   typedef enum logic [OP_W-1:0] {
      OP_GET   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_ANY   = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // capture the input word
      logic start_zero;   // word counter to zero
      logic start_first;  // word counter to the first word of the item
      logic inc;          // word counter plus one
      logic wr_set;       // write back the read word with the bit updated
      logic wr_zero;      // write zero at the counter
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   word_ok;     // start word lies inside the store
      logic   range_empty; // nothing to scan for the range query
      logic   cur_last;    // counter sits on the last word to visit
      logic   sweep_done;  // counter sits on the last word of the store
      logic   hit;         // masked read word holds a one
      logic   get_bit;     // selected bit of the read word
   } status_type;

endpackage

>>> hw/rtl/bara_ram.sv
module bara_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/bara_dp.sv
module bara_dp #(
   parameter int NUM_WORDS = bara_pkg::NUM_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bara_pkg::OP_W-1:0]   req_operation,
   input  logic [bara_pkg::IDX_W-1:0]  req_index,
   input  logic                        req_bit_value,
   input  logic [bara_pkg::END_W-1:0]  req_range_end,
   input  bara_pkg::cmd_type           cmd,
   output bara_pkg::status_type        status
);
   import bara_pkg::*;

   localparam int DEPTH = (NUM_WORDS < WORDS_MAX) ? NUM_WORDS : WORDS_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(DEPTH - 1);

   op_type             op_ff;
   logic [IDX_W-1:0]   lo_ff;
   logic [END_W-1:0]   hi_ff;
   logic               val_ff;
   logic [CNT_W-1:0]   cur_ff, cur_in;

   logic [END_W-1:0]   hi_m1;
   logic [CNT_W-1:0]   word_lo, word_hi, word_end, last_word;
   logic [WORD_BITS-1:0] rd_data, wr_data, bit_mask, mask_lo, mask_hi;
   logic               wr_en;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_operation);
         lo_ff  <= req_index;
         hi_ff  <= req_range_end;
         val_ff <= req_bit_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   always_comb begin
      hi_m1    = hi_ff - END_W'(1);
      word_lo  = {1'b0, lo_ff[IDX_W-1:SEL_W]};
      // The end of a range may lie past the index space, so all of its word bits are kept.
      word_hi  = hi_m1[END_W-1:SEL_W];
      // Clear reaches the word of the index; the range query the word of its last bit.
      word_end = (op_ff == OP_CLEAR) ? word_lo : word_hi;
      last_word = (word_end > LAST_ADDR) ? LAST_ADDR : word_end;

      cur_in = cur_ff;
      if (cmd.start_zero) begin
         cur_in = '0;
      end else if (cmd.start_first) begin
         cur_in = word_lo;
      end else if (cmd.inc) begin
         cur_in = cur_ff + CNT_W'(1);
      end

      // Partial first and last words of a range are masked.
      mask_lo = (cur_ff == word_lo) ? ({WORD_BITS{1'b1}} << lo_ff[SEL_W-1:0])
                                    : {WORD_BITS{1'b1}};
      mask_hi = (cur_ff == word_hi)
                ? ({WORD_BITS{1'b1}} >> (SEL_W'(WORD_BITS - 1) - hi_m1[SEL_W-1:0]))
                : {WORD_BITS{1'b1}};

      bit_mask = WORD_BITS'(1) << lo_ff[SEL_W-1:0];
      wr_en    = cmd.wr_set | cmd.wr_zero;
      if (cmd.wr_zero) begin
         wr_data = '0;
      end else if (val_ff) begin
         wr_data = rd_data | bit_mask;
      end else begin
         wr_data = rd_data & ~bit_mask;
      end

      status.op          = op_ff;
      status.word_ok     = (word_lo <= LAST_ADDR);
      status.range_empty = ({1'b0, lo_ff} >= hi_ff) || (word_lo > last_word);
      status.cur_last    = (cur_ff == last_word);
      status.sweep_done  = (cur_ff == LAST_ADDR);
      status.hit         = |(rd_data & mask_lo & mask_hi);
      status.get_bit     = rd_data[lo_ff[SEL_W-1:0]];
   end

   bara_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (rd_data)
   );

endmodule

>>> hw/rtl/bara_ctrl.sv
module bara_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_answer,
   input  bara_pkg::status_type   status,
   output bara_pkg::cmd_type      cmd
);
   import bara_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_EVAL,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      ans_ff, ans_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_answer_ff, rsp_answer_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      ans_in        = ans_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;

      case (state_ff)
         ST_INIT: begin
            cmd.wr_zero = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (status.op)
               OP_GET, OP_SET: begin
                  if (status.word_ok) begin
                     cmd.start_first = 1'b1;
                     state_in        = ST_READ;
                  end else if (status.op == OP_GET) begin
                     ans_in   = 1'b0;
                     state_in = ST_RESULT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_CLEAR: begin
                  cmd.start_zero = 1'b1;
                  state_in       = ST_CLEAR;
               end
               default: begin
                  if (status.range_empty) begin
                     ans_in   = 1'b0;
                     state_in = ST_RESULT;
                  end else begin
                     cmd.start_first = 1'b1;
                     state_in        = ST_READ;
                  end
               end
            endcase
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (status.op)
               OP_GET: begin
                  ans_in   = status.get_bit;
                  state_in = ST_RESULT;
               end
               OP_SET: begin
                  cmd.wr_set = 1'b1;
                  state_in   = ST_IDLE;
               end
               default: begin
                  if (status.hit) begin
                     ans_in   = 1'b1;
                     state_in = ST_RESULT;
                  end else if (status.cur_last) begin
                     ans_in   = 1'b0;
                     state_in = ST_RESULT;
                  end else begin
                     cmd.inc  = 1'b1;
                     state_in = ST_READ;
                  end
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.wr_zero = 1'b1;
            if (status.cur_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.inc = 1'b1;
            end
         end
         ST_RESULT: begin
            // Wait until the output register is empty or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ans_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         rsp_valid_ff  <= 1'b0;
         ans_ff        <= 1'b0;
         rsp_answer_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         ans_ff        <= ans_in;
         rsp_answer_ff <= rsp_answer_in;
      end
   end

endmodule

>>> hw/rtl/bit_array_with_range_any_core.sv
// Bit array of NUM_WORDS 32-bit words (bit i in word i/32, position i%32) with four
// operations: get one bit, set one bit to 0 or 1, clear words 0 through index/32
// (stopping at the last word), and report whether any bit in [index, range_end) is 1.
// Get and the range query return one answer word; set and clear return nothing.
// Words past the end of the store read as zero and ignore writes. After reset the
// block walks through the store writing zeros, one word per cycle, and accepts no
// word until it has zeroed the last word. The store is a single-port-style RAM with a
// registered read, and every operation goes through it one word at a time, so the
// cost of an item is set by that port: get and set pass through accept, start, read
// and check or write back, and a get answer then goes through a result step into the
// output register. Clear zeroes the words one at a time after accept and start, and a
// range query reads and checks each word in turn, ending early at the first word
// that holds a one. The output register lets the next word be accepted while an
// answer still waits for rsp_ready.
module bit_array_with_range_any_core #(
   parameter int NUM_WORDS = bara_pkg::NUM_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bara_pkg::OP_W-1:0]   req_operation,
   input  logic [bara_pkg::IDX_W-1:0]  req_index,
   input  logic                        req_bit_value,
   input  logic [bara_pkg::END_W-1:0]  req_range_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_answer
);
   import bara_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences each operation; the datapath holds the item,
   // the word counter and the store.
   bara_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_answer (rsp_answer),
      .status     (status),
      .cmd        (cmd)
   );

   bara_dp #(
      .NUM_WORDS (NUM_WORDS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_bit_value (req_bit_value),
      .req_range_end (req_range_end),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

>>> tb/sv/bit_array_with_range_any_core_tb.sv
module bit_array_with_range_any_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bara_pkg::*;

   // The 15-bit index reaches exactly NUM_WORDS_DEF words, so with the default size every
   // bit an item can name lives inside the store. The guards for words past the end are
   // kept in the predictor anyway, so that it stays right if the size changes.
   localparam int NUM_WORDS    = NUM_WORDS_DEF;
   localparam int MAX_BIT      = 2 ** IDX_W - 1;
   localparam int RANGE_TOP    = 2 ** IDX_W;
   localparam int RANDOM_WORDS = 680;
   localparam int LONG_GAP     = 60;
   localparam int HOLD_CYCLES  = 400;
   // The slowest item is a range query over the whole store, which reads and checks every word.
   // This many cycles covers it after the last answer, in case a clear is still running.
   localparam int DRAIN_CYCLES = 2200;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  index;
      logic              bit_value;
      logic [END_W-1:0]  range_end;
   } req_word_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  index;
      logic              answer;
   } answer_type;

   // Every input has a known value from time zero; reset is held from the start.
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation = '0;
   logic [IDX_W-1:0]   req_index     = '0;
   logic               req_bit_value = 1'b0;
   logic [END_W-1:0]   req_range_end = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic               rsp_answer;

   // Our own copy of the bit array, updated as each word is accepted.
   logic [31:0]        bit_store [NUM_WORDS];

   req_word_type       pending_words [$];
   answer_type         expected_answers [$];
   req_word_type       cur_word;
   answer_type         due;

   int unsigned        gap_left      = 0;
   int unsigned        stall_left    = 0;
   logic               hold_off      = 1'b0;
   logic               quiet;
   int unsigned        cycle_count   = 0;
   longint unsigned    cycle_limit   = 64'hFFFF_FFFF;
   longint unsigned    workload_bound = 0;
   int unsigned        error_count   = 0;
   int unsigned        answers_seen  = 0;
   int unsigned        ones_seen     = 0;
   int unsigned        op_count [4]  = '{0, 0, 0, 0};

   bit_array_with_range_any_core #(
      .NUM_WORDS (NUM_WORDS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_bit_value (req_bit_value),
      .req_range_end (req_range_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_answer    (rsp_answer)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // One quarter of the time neither side idles at all, so back-to-back traffic is seen
   // as well as traffic with gaps.
   assign quiet = (cycle_count % 2000) >= 1500;

   // Gap length for either side: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, LONG_GAP);
   endfunction

   // True when some bit in the half-open range [lo, hi) is set. The first and last words
   // are masked to the range; the words in between are checked whole.
   function automatic logic any_in_range(int unsigned lo, int unsigned hi);
      int unsigned w_first, w_last, base, s, e;
      logic [31:0] mask;
      logic [31:0] stored;
      if (hi <= lo) return 1'b0;
      w_first = lo >> 5;
      w_last  = (hi - 1) >> 5;
      if (w_last >= NUM_WORDS) w_last = NUM_WORDS - 1;
      for (int unsigned w = w_first; w <= w_last; w++) begin
         base   = w << 5;
         s      = (lo > base) ? lo - base : 0;
         e      = (hi < base + 32) ? hi - base : 32;
         mask   = (e >= 32) ? 32'hFFFF_FFFF : (32'd1 << e) - 32'd1;
         mask   = mask & (32'hFFFF_FFFF << s);
         stored = (w < NUM_WORDS) ? bit_store[w] : 32'd0;
         if ((stored & mask) != 32'd0) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one accepted word to the bit array and queues the answer it should produce.
   // Get and range queries answer; set and clear only change the array.
   function automatic void track_word(req_word_type w);
      int unsigned widx, last;
      answer_type  item;
      widx       = w.index >> 5;
      item.op    = w.op;
      item.index = w.index;
      op_count[int'(w.op)]++;
      case (w.op)
         OP_GET: begin
            item.answer = (widx < NUM_WORDS) ? bit_store[widx][w.index[4:0]] : 1'b0;
            expected_answers.push_back(item);
         end
         OP_SET: begin
            if (widx < NUM_WORDS) bit_store[widx][w.index[4:0]] = w.bit_value;
         end
         OP_CLEAR: begin
            // Clearing starts at word 0 and ends at the index's word, capped at the last word.
            last = (widx >= NUM_WORDS) ? NUM_WORDS - 1 : widx;
            for (int unsigned i = 0; i <= last; i++) bit_store[i] = 32'd0;
         end
         default: begin
            item.answer = any_in_range(w.index, w.range_end);
            expected_answers.push_back(item);
         end
      endcase
   endfunction

   // Queues one word for the driver and adds its worst-case cost to the cycle budget:
   // the longest gap on each side plus the cycles the block spends walking words.
   function automatic void queue_word(op_type op, int unsigned index, bit value,
                                      int unsigned range_end);
      req_word_type    w;
      longint unsigned cost;
      w.op        = op;
      w.index     = index[IDX_W-1:0];
      w.bit_value = value;
      w.range_end = range_end[END_W-1:0];
      pending_words.push_back(w);
      cost = 2 * LONG_GAP + 10;
      if (op == OP_CLEAR)
         cost += ((index >> 5) >= NUM_WORDS ? NUM_WORDS - 1 : index >> 5) + 1;
      if (op == OP_ANY && range_end > index)
         cost += 2 * (((range_end - 1) >> 5) - (index >> 5) + 1) + 3;
      workload_bound += cost;
   endfunction

   // A bit index close to a given one, kept inside the index space.
   function automatic int unsigned near_bit(int unsigned center, int unsigned spread);
      int v;
      v = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      if (v > MAX_BIT) v = MAX_BIT;
      return v;
   endfunction

   // Driver: offers the next pending word as soon as the previous one is accepted and
   // its gap has run out. The prediction is made at the edge where the word is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) track_word(cur_word);
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               cur_word       = pending_words.pop_front();
               req_operation <= cur_word.op;
               req_index     <= cur_word.index;
               req_bit_value <= cur_word.bit_value;
               req_range_end <= cur_word.range_end;
               req_valid     <= 1'b1;
               gap_left      <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, and one long hold-off while the sender keeps offering words,
   // which fills the output register and the word in flight and backs up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) stall_left <= pick_gap();
      end
   end

   initial begin
      while (answers_seen < 40) @(negedge clock);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Monitor: every answer word is checked against the oldest one still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            $error("answer word %0b arrived with no answer expected", rsp_answer);
            error_count++;
         end else begin
            due = expected_answers.pop_front();
            if (rsp_answer !== due.answer) begin
               $error("answer mismatch (op %0d, index %0d): expected %0b, actual %0b",
                      due.op, due.index, due.answer, rsp_answer);
               error_count++;
            end
            answers_seen++;
            if (rsp_answer === 1'b1) ones_seen++;
         end
      end
   end

   // Watchdog against a hung block or an answer that never comes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= cycle_limit) begin
         $display("timeout after %0d cycles, %0d answers still owed",
                  cycle_count, expected_answers.size());
         $display("bit_array_with_range_any_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int unsigned r, lo, hi, mark;
      bit          val;
      int unsigned set_marks [$];

      // Directed words first. The store starts empty, so the first get and the full range
      // query must both answer zero. Then the top bit is set and found again by a get,
      // a full range query and a one-bit range at the very end of the index space.
      queue_word(OP_GET,   0,       0, 0);
      queue_word(OP_ANY,   0,       0, RANGE_TOP);
      queue_word(OP_SET,   MAX_BIT, 1, 0);
      queue_word(OP_GET,   MAX_BIT, 0, 0);
      queue_word(OP_ANY,   0,       0, RANGE_TOP);
      // An empty range and a range whose end lies below its start both answer zero.
      queue_word(OP_ANY,   MAX_BIT, 0, MAX_BIT);
      queue_word(OP_ANY,   MAX_BIT, 0, 5);
      queue_word(OP_ANY,   MAX_BIT, 1, RANGE_TOP);
      // An end far past the index space still covers the top bit.
      queue_word(OP_ANY,   MAX_BIT, 0, 2 ** END_W - 1);
      // Bit 0 and the top bit are set; a range that excludes both by one bit answers zero.
      queue_word(OP_SET,   0,       1, 0);
      queue_word(OP_ANY,   1,       0, MAX_BIT);
      queue_word(OP_ANY,   0,       0, 1);
      queue_word(OP_SET,   0,       0, 0);
      queue_word(OP_GET,   0,       0, 0);
      // Both sides of the first word boundary, so the masks on partial words are exercised.
      queue_word(OP_SET,   31,      1, 0);
      queue_word(OP_SET,   32,      1, 0);
      queue_word(OP_ANY,   31,      0, 32);
      queue_word(OP_ANY,   32,      0, 33);
      queue_word(OP_ANY,   0,       0, 31);
      queue_word(OP_ANY,   33,      0, 64);
      // A clear up to bit 31 wipes word 0 only, so bit 32 survives.
      queue_word(OP_CLEAR, 31,      0, 0);
      queue_word(OP_GET,   31,      0, 0);
      queue_word(OP_GET,   32,      0, 0);
      // A clear from the top index reaches the last word, leaving the whole store empty.
      queue_word(OP_CLEAR, MAX_BIT, 1, RANGE_TOP);
      queue_word(OP_GET,   MAX_BIT, 0, 0);
      queue_word(OP_ANY,   0,       0, RANGE_TOP);

      // Random words. Sets leave a trail of recently set bits, and most gets and range
      // queries aim near that trail, so answers are a mix of ones and zeros. Most ranges
      // and clears are short; a few reach far across the store.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         r    = $urandom_range(0, 99);
         mark = (set_marks.size() != 0) ? set_marks[$urandom_range(0, set_marks.size() - 1)]
                                        : $urandom_range(0, MAX_BIT);
         if (r < 35) begin
            lo  = ($urandom_range(0, 2) == 0) ? near_bit(mark, 40) : $urandom_range(0, MAX_BIT);
            val = ($urandom_range(0, 3) != 0);
            queue_word(OP_SET, lo, val, $urandom_range(0, RANGE_TOP));
            if (val) begin
               set_marks.push_back(lo);
               if (set_marks.size() > 64) set_marks.delete(0);
            end
         end else if (r < 55) begin
            lo = ($urandom_range(0, 4) < 3) ? near_bit(mark, 1) : $urandom_range(0, MAX_BIT);
            queue_word(OP_GET, lo, $urandom_range(0, 1), $urandom_range(0, RANGE_TOP));
         end else if (r < 90) begin
            lo = ($urandom_range(0, 1) == 0) ? near_bit(mark, 48) : $urandom_range(0, MAX_BIT);
            r  = $urandom_range(0, 99);
            if (r < 5)       hi = $urandom_range(0, lo);
            else if (r < 84) hi = lo + $urandom_range(0, 100);
            else if (r < 96) hi = lo + $urandom_range(0, 2000);
            else             hi = $urandom_range(lo, RANGE_TOP);
            if (hi > RANGE_TOP) hi = RANGE_TOP;
            queue_word(OP_ANY, lo, $urandom_range(0, 1), hi);
         end else begin
            lo = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(0, MAX_BIT);
            queue_word(OP_CLEAR, lo, $urandom_range(0, 1), $urandom_range(0, RANGE_TOP));
         end
      end

      // The budget covers the clearing pass after reset, the hold-off, the final wait and
      // every word at its slowest, taken four times over.
      cycle_limit = 4 * (workload_bound + NUM_WORDS + HOLD_CYCLES + DRAIN_CYCLES) + 10000;

      // The predictor starts from the same empty store as the block after reset.
      for (int i = 0; i < NUM_WORDS; i++) bit_store[i] = 32'd0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Sampling on the falling edge keeps these checks clear of the driver's updates.
      while (pending_words.size() != 0 || req_valid) @(negedge clock);
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d get, %0d set, %0d clear, %0d range queries.",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("Checked %0d answers, %0d of them ones, in %0d cycles.",
               answers_seen, ones_seen, cycle_count);
      if (error_count == 0) begin
         $display("bit_array_with_range_any_core_tb OK");
      end else begin
         $display("bit_array_with_range_any_core_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> bit_array_with_range_any_core.f
hw/rtl/bara_pkg.sv
hw/rtl/bara_ram.sv
hw/rtl/bara_dp.sv
hw/rtl/bara_ctrl.sv
hw/rtl/bit_array_with_range_any_core.sv
tb/sv/bit_array_with_range_any_core_tb.sv
